FILE: hdl/ppq_pkg.sv
`timescale 1ns / 1ps

package ppq_pkg;

  // fixed field widths
  localparam int COORD_BITS       = 24;
  localparam int DIST_BITS        = 2 * COORD_BITS + 2;
  localparam int IDX_BITS         = 6;
  localparam int CNT_BITS         = 7;
  localparam int T_FRAC           = 16;
  localparam int MAX_VERTICES_DEF = 64;

  // edge arithmetic widths
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * DIFF_BITS;
  localparam int SUM_BITS  = PROD_BITS + 1;
  localparam int DIV_BITS  = SUM_BITS + 1;

  // command codes on in_tuser
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // query sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_EDGE,
    ST_MUL,
    ST_SUM,
    ST_DECIDE,
    ST_DIV,
    ST_PROJ,
    ST_QPT,
    ST_DMUL,
    ST_CMP,
    ST_DONE
  } ppq_state_t;

  // request to the edge parameter divider
  typedef struct packed {
    logic                start;
    logic [DIV_BITS-1:0] num;
    logic [DIV_BITS-1:0] den;
  } div_req_t;

endpackage

FILE: hdl/ppq_vertex_mem.sv
`timescale 1ns / 1ps

module ppq_vertex_mem
  import ppq_pkg::*;
#(
  parameter int DEPTH = MAX_VERTICES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic [2*COORD_BITS-1:0] wr_data,
  input  logic                    rd_en,
  input  logic [AW-1:0]           rd_addr,
  output logic [2*COORD_BITS-1:0] rd_data
);

  logic [2*COORD_BITS-1:0] mem [DEPTH];
  logic [2*COORD_BITS-1:0] rd_data_r;

  // vertex write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/ppq_div.sv
`timescale 1ns / 1ps

module ppq_div
  import ppq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  div_req_t          req,
  output logic              done,
  output logic [T_FRAC-1:0] quot
);

  localparam int STEPS = T_FRAC / 2;
  localparam int SCW   = $clog2(STEPS + 1);

  logic [DIV_BITS-1:0] rem_r, den_r;
  logic [T_FRAC-1:0]   q_r;
  logic [SCW-1:0]      cnt_r;
  logic                busy_r, done_r;
  logic [DIV_BITS-1:0] rem_w;
  logic [T_FRAC-1:0]   q_w;

  // two restoring steps per cycle
  always_comb begin
    rem_w = rem_r;
    q_w   = q_r;
    for (int k = 0; k < 2; k++) begin
      rem_w = rem_w << 1;
      q_w   = q_w << 1;
      if (rem_w >= den_r) begin
        rem_w = rem_w - den_r;
        q_w   = q_w | T_FRAC'(1);
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + SCW'(1);
        if (cnt_r == SCW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num;
      den_r <= req.den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_w;
      q_r   <= q_w;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

FILE: hdl/polygon_point_query_core.sv
`timescale 1ns / 1ps

// Polygon point query core. Load requests (in_tuser = 0) write one vertex
// into the vertex memory and give no result. A query request (in_tuser = 1)
// walks the n = min(vertex_count, MAX_VERTICES) closed-polygon edges one at
// a time, reading one vertex per edge from the memory, and returns the
// even-odd inside flag, the nearest boundary point and its squared distance.
// Each edge steps through EDGE, MUL, SUM, DECIDE, PROJ, QPT, DMUL and CMP,
// with DIV after DECIDE when t needs the 2-bit-per-cycle divider; with
// fewer than two vertices a query goes straight to DONE. A finished result
// waits in the output register while the next request is accepted.
// vertex_count must be written only while the core is idle (not enforced).

module polygon_point_query_core
  import ppq_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // vertex_count register
  input  logic                cfg_wr_en,
  input  logic [CNT_BITS-1:0] cfg_wr_data,
  // requests
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [55:0]         in_tdata,   // vertex_index, coord_x, coord_y
  input  logic                in_tuser,   // command
  // results
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [103:0]        out_tdata   // inside_res, closest_x, closest_y,
                                          // distance_squared
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int CB = COORD_BITS;
  localparam int QW = CB + 2;
  localparam int TW = T_FRAC + 2;
  localparam int TPW = TW + DIFF_BITS;
  localparam int SQW = 2 * QW;

  // request fields
  logic [IDX_BITS-1:0] vertex_index;
  logic signed [CB-1:0] coord_x, coord_y;
  assign vertex_index = in_tdata[IDX_BITS-1:0];
  assign coord_x      = in_tdata[IDX_BITS +: CB];
  assign coord_y      = in_tdata[IDX_BITS+CB +: CB];

  ppq_state_t state_r, state_nxt;
  logic [CNT_BITS-1:0] vertex_count_r;
  logic [CW-1:0] n_w, n_r, idx_r;

  logic signed [CB-1:0] px_r, py_r, ax_r, ay_r, fx_r, fy_r, bx_r, by_r;
  logic signed [CB-1:0] bx_w, by_w;
  logic signed [DIFF_BITS-1:0] ex_r, ey_r, wx_r, wy_r;
  logic xcond_r, eypos_r, inside_r;
  logic signed [PROD_BITS-1:0] pdx_r, pdy_r, plx_r, ply_r, plhs_r, prhs_r;
  logic signed [SUM_BITS-1:0] dot_r, len_r;
  logic signed [TW-1:0] t_r;
  logic signed [TPW-1:0] tx_r, ty_r;
  logic signed [QW-1:0] qx_w, qy_w, dx_w, dy_w, dx_r, dy_r;
  logic signed [CB-1:0] qx_r, qy_r;
  logic [SQW-1:0] sqx_r, sqy_r;
  logic [SQW:0] d2_w;
  logic [DIST_BITS-1:0] best_d_r;
  logic signed [CB-1:0] best_x_r, best_y_r;
  logic out_tvalid_r, out_inside_r;
  logic [CB-1:0] out_x_r, out_y_r;
  logic [DIST_BITS-1:0] out_d_r;

  logic in_acc, is_load, is_query, last_edge, t_trivial, out_free;
  logic mem_we, mem_re;
  logic [AW-1:0] mem_raddr;
  logic [2*CB-1:0] mem_rdata;
  div_req_t div_req;
  logic div_done;
  logic [T_FRAC-1:0] div_q;

  assign in_acc   = in_tvalid && in_tready;
  assign is_load  = in_acc && (in_tuser == CMD_LOAD);
  assign is_query = in_acc && (in_tuser == CMD_QUERY);
  assign out_free = !out_tvalid_r || out_tready;
  assign last_edge = (idx_r == n_r);
  assign n_w = (int'(vertex_count_r) > MAX_VERTICES) ? CW'(MAX_VERTICES)
                                                      : CW'(vertex_count_r);
  assign t_trivial = (len_r <= 0) || (dot_r <= 0) || (dot_r >= len_r);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= '0;
    end else if (cfg_wr_en) begin
      vertex_count_r <= cfg_wr_data;
    end
  end

  // vertex memory, x in the low half
  assign mem_we = is_load && (int'(vertex_index) < MAX_VERTICES);

  ppq_vertex_mem #(.DEPTH(MAX_VERTICES), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (AW'(vertex_index)),
    .wr_data ({coord_y, coord_x}),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  ppq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (is_query) begin
          state_nxt = (n_w < CW'(2)) ? ST_DONE : ST_FIRST;
        end
      end
      ST_FIRST:  state_nxt = ST_EDGE;
      ST_EDGE:   state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = t_trivial ? ST_PROJ : ST_DIV;
      ST_DIV:    state_nxt = div_done ? ST_PROJ : ST_DIV;
      ST_PROJ:   state_nxt = ST_QPT;
      ST_QPT:    state_nxt = ST_DMUL;
      ST_DMUL:   state_nxt = ST_CMP;
      ST_CMP:    state_nxt = last_edge ? ST_DONE : ST_EDGE;
      ST_DONE:   state_nxt = out_free ? ST_IDLE : ST_DONE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    div_req.start = 1'b0;
    div_req.num   = DIV_BITS'(unsigned'(dot_r));
    div_req.den   = DIV_BITS'(unsigned'(len_r));
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        mem_re    = 1'b1;
      end
      ST_FIRST: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(CW'(1));
      end
      ST_DECIDE: div_req.start = !t_trivial;
      ST_CMP: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(idx_r + CW'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // far end of the current edge wraps to the first vertex
  assign bx_w = last_edge ? fx_r : mem_rdata[CB-1:0];
  assign by_w = last_edge ? fy_r : mem_rdata[2*CB-1:CB];

  // projection point and offset to the query point
  assign qx_w = QW'(ax_r) + QW'(tx_r >>> T_FRAC);
  assign qy_w = QW'(ay_r) + QW'(ty_r >>> T_FRAC);
  assign dx_w = QW'(px_r) - qx_w;
  assign dy_w = QW'(py_r) - qy_w;
  assign d2_w = (SQW+1)'(sqx_r) + (SQW+1)'(sqy_r);

  // edge datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (is_query) begin
          px_r     <= coord_x;
          py_r     <= coord_y;
          n_r      <= n_w;
          inside_r <= 1'b0;
          best_x_r <= coord_x;
          best_y_r <= coord_y;
          best_d_r <= '0;
        end
      end
      ST_FIRST: begin
        fx_r  <= mem_rdata[CB-1:0];
        fy_r  <= mem_rdata[2*CB-1:CB];
        ax_r  <= mem_rdata[CB-1:0];
        ay_r  <= mem_rdata[2*CB-1:CB];
        idx_r <= CW'(1);
      end
      ST_EDGE: begin
        bx_r    <= bx_w;
        by_r    <= by_w;
        ex_r    <= DIFF_BITS'(bx_w) - DIFF_BITS'(ax_r);
        ey_r    <= DIFF_BITS'(by_w) - DIFF_BITS'(ay_r);
        wx_r    <= DIFF_BITS'(px_r) - DIFF_BITS'(ax_r);
        wy_r    <= DIFF_BITS'(py_r) - DIFF_BITS'(ay_r);
        xcond_r <= (ay_r > py_r) != (by_w > py_r);
        eypos_r <= by_w > ay_r;
      end
      ST_MUL: begin
        pdx_r  <= wx_r * ex_r;
        pdy_r  <= wy_r * ey_r;
        plx_r  <= ex_r * ex_r;
        ply_r  <= ey_r * ey_r;
        plhs_r <= wx_r * ey_r;
        prhs_r <= ex_r * wy_r;
      end
      ST_SUM: begin
        dot_r <= SUM_BITS'(pdx_r) + SUM_BITS'(pdy_r);
        len_r <= SUM_BITS'(plx_r) + SUM_BITS'(ply_r);
        // even-odd crossing by exact cross-multiplication
        if (n_r >= CW'(3) && xcond_r &&
            (eypos_r ? (plhs_r < prhs_r) : (plhs_r > prhs_r))) begin
          inside_r <= !inside_r;
        end
      end
      ST_DECIDE: begin
        if (len_r <= 0 || dot_r <= 0) begin
          t_r <= '0;
        end else begin
          t_r <= TW'(1) <<< T_FRAC;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          t_r <= TW'(div_q);
        end
      end
      ST_PROJ: begin
        tx_r <= t_r * ex_r;
        ty_r <= t_r * ey_r;
      end
      ST_QPT: begin
        qx_r <= CB'(qx_w);
        qy_r <= CB'(qy_w);
        dx_r <= dx_w;
        dy_r <= dy_w;
      end
      ST_DMUL: begin
        sqx_r <= SQW'(dx_r * dx_r);
        sqy_r <= SQW'(dy_r * dy_r);
      end
      ST_CMP: begin
        // first edge always taken, ties keep the earlier edge
        if (idx_r == CW'(1) || DIST_BITS'(d2_w) < best_d_r) begin
          best_d_r <= DIST_BITS'(d2_w);
          best_x_r <= qx_r;
          best_y_r <= qy_r;
        end
        ax_r  <= bx_r;
        ay_r  <= by_r;
        idx_r <= idx_r + CW'(1);
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_inside_r <= inside_r;
      out_x_r      <= best_x_r;
      out_y_r      <= best_y_r;
      out_d_r      <= best_d_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'b0, out_d_r, out_y_r, out_x_r, out_inside_r};

endmodule

FILE: sim/polygon_point_query_checker.sv
`timescale 1ns / 1ps

module polygon_point_query_checker
  import ppq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CNT_BITS-1:0] cfg_wr_data,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [55:0]         in_tdata,   // vertex_index, coord_x, coord_y
  input  logic                in_tuser,   // command
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [103:0]        out_tdata,  // inside_res, closest_x, closest_y,
                                          // distance_squared
  output int                  mismatches,
  output int                  pending,
  output int                  queries_seen
);

  // packed from the top bit down, so inside_flag lands in bit 0
  typedef struct packed {
    logic [DIST_BITS-1:0]  dist_sq;
    logic [COORD_BITS-1:0] cy;
    logic [COORD_BITS-1:0] cx;
    logic                  inside_flag;
  } query_result_t;

  query_result_t  result_q[$];
  longint         poly_x[64];
  longint         poly_y[64];
  int unsigned    poly_count;

  // t = dot/len2 with 16 fraction bits, clamped to 0..1
  function automatic longint edge_t(longint dot, longint len2);
    longint rem;
    longint t;
    rem = dot;
    t = 0;
    if (len2 <= 0 || dot <= 0) return 0;
    if (dot >= len2) return longint'(1) << T_FRAC;
    for (int k = 0; k < T_FRAC; k++) begin
      rem = rem <<< 1;
      t = t <<< 1;
      if (rem >= len2) begin
        rem = rem - len2;
        t = t | 1;
      end
    end
    return t;
  endfunction

  // divide by 2^16 rounding toward minus infinity
  function automatic longint floor_frac(longint v);
    return v >>> T_FRAC;
  endfunction

  function automatic query_result_t query_polygon(longint px, longint py);
    query_result_t r;
    int unsigned   n;
    int unsigned   j;
    int unsigned   nx;
    logic          ins;
    longint        bx, by, bd;
    longint        dy, lhs, rhs, ex, ey, dot, len2, t, qx, qy, dx, dyy, d2;
    n = (poly_count > 64) ? 64 : poly_count;
    ins = 1'b0;
    bx = px;
    by = py;
    bd = 0;
    // even-odd crossing count
    if (n >= 3) begin
      j = n - 1;
      for (int unsigned i = 0; i < n; i++) begin
        if ((poly_y[i] > py) != (poly_y[j] > py)) begin
          dy = poly_y[j] - poly_y[i];
          lhs = (px - poly_x[i]) * dy;
          rhs = (poly_x[j] - poly_x[i]) * (py - poly_y[i]);
          if (dy > 0 ? (lhs < rhs) : (lhs > rhs)) ins = !ins;
        end
        j = i;
      end
    end
    // nearest boundary point, first edge wins a tie
    if (n >= 2) begin
      for (int unsigned i = 0; i < n; i++) begin
        nx = (i + 1 == n) ? 0 : i + 1;
        ex = poly_x[nx] - poly_x[i];
        ey = poly_y[nx] - poly_y[i];
        dot = (px - poly_x[i]) * ex + (py - poly_y[i]) * ey;
        len2 = ex * ex + ey * ey;
        t = edge_t(dot, len2);
        qx = poly_x[i] + floor_frac(t * ex);
        qy = poly_y[i] + floor_frac(t * ey);
        dx = px - qx;
        dyy = py - qy;
        d2 = dx * dx + dyy * dyy;
        if (i == 0 || d2 < bd) begin
          bd = d2;
          bx = qx;
          by = qy;
        end
      end
    end
    r.inside_flag = ins;
    r.cx = bx[COORD_BITS-1:0];
    r.cy = by[COORD_BITS-1:0];
    r.dist_sq = bd[DIST_BITS-1:0];
    return r;
  endfunction

  // track config and requests, compare results
  always @(posedge clk) begin
    query_result_t got;
    query_result_t want;
    if (!rst_n) begin
      poly_count <= 0;
      mismatches <= 0;
      queries_seen <= 0;
      pending <= 0;
      result_q.delete();
      for (int i = 0; i < 64; i++) begin
        poly_x[i] = 0;
        poly_y[i] = 0;
      end
    end else begin
      if (cfg_wr_en) poly_count <= cfg_wr_data;
      if (in_tvalid && in_tready) begin
        if (in_tuser == CMD_LOAD) begin
          poly_x[in_tdata[5:0]] = longint'($signed(in_tdata[29:6]));
          poly_y[in_tdata[5:0]] = longint'($signed(in_tdata[53:30]));
        end else begin
          result_q.push_back(query_polygon(longint'($signed(in_tdata[29:6])),
                                           longint'($signed(in_tdata[53:30]))));
          queries_seen <= queries_seen + 1;
        end
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[98:0];
        if (result_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %h", got);
          mismatches <= mismatches + 1;
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("result mismatch: inside %b/%b x %h/%h y %h/%h d2 %h/%h",
                       want.inside_flag, got.inside_flag, want.cx, got.cx,
                       want.cy, got.cy, want.dist_sq, got.dist_sq);
            mismatches <= mismatches + 1;
          end
        end
      end
      pending <= result_q.size();
    end
  end

endmodule

FILE: sim/polygon_point_query_core_tb.sv
`timescale 1ns / 1ps

module polygon_point_query_core_tb;
  import ppq_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [CNT_BITS-1:0] cfg_wr_data = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [55:0]         in_tdata = '0;   // vertex_index, coord_x, coord_y
  logic                in_tuser = CMD_LOAD;   // command
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [103:0]        out_tdata;  // inside_res, closest_x, closest_y,
                                   // distance_squared
  int                  mismatches;
  int                  pending;
  int                  queries_seen;
  int                  sender_idle_pct = 0;
  int                  receiver_stall_pct = 0;
  logic                hold_results = 1'b0;
  logic [63:0]         slot_loaded = '0;
  int                  stall_cycles = 0;
  int                  coord_range = 23;

  always #1 clk = ~clk;

  polygon_point_query_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  polygon_point_query_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .mismatches(mismatches), .pending(pending), .queries_seen(queries_seen)
  );

  // result side back-pressure
  always @(posedge clk)
    out_tready <= !hold_results && ($urandom_range(99) >= receiver_stall_pct);

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [23:0] rand_coord();
    longint span;
    span = longint'(1) << coord_range;
    return 24'(longint'($urandom_range(2 * span - 1)) - span);
  endfunction

  task automatic send_request(logic cmd, logic [5:0] idx, logic [23:0] x, logic [23:0] y);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {2'b00, y, x, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == CMD_LOAD) slot_loaded[idx] = 1'b1;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // vertex_count only changes with the core idle
  task automatic set_vertex_count(int value);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= CNT_BITS'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    for (int i = 0; i < ((value > 64) ? 64 : value); i++)
      if (!slot_loaded[i]) send_request(CMD_LOAD, 6'(i), rand_coord(), rand_coord());
  endtask

  initial begin
    int counts[12] = '{3, 0, 4, 1, 5, 2, 6, 64, 8, 127, 3, 12};
    int ranges[4] = '{10, 23, 16, 6};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, short polygons, zero-length edge
    send_request(CMD_QUERY, 6'd0, 24'h800000, 24'h7fffff);
    send_request(CMD_LOAD, 6'd0, 24'h800000, 24'h800000);
    send_request(CMD_LOAD, 6'd1, 24'h7fffff, 24'h800000);
    send_request(CMD_LOAD, 6'd2, 24'h7fffff, 24'h7fffff);
    send_request(CMD_LOAD, 6'd3, 24'h7fffff, 24'h7fffff);
    set_vertex_count(1);
    send_request(CMD_QUERY, 6'd63, 24'h000123, 24'hfff000);
    set_vertex_count(2);
    send_request(CMD_QUERY, 6'd0, 24'h000000, 24'h000000);
    send_request(CMD_QUERY, 6'd0, 24'h7fffff, 24'h800000);
    set_vertex_count(4);
    send_request(CMD_QUERY, 6'd0, 24'h000000, 24'h000000);
    send_request(CMD_QUERY, 6'd0, 24'h800000, 24'h7fffff);
    send_request(CMD_QUERY, 6'd0, 24'h7fffff, 24'h000000);
    send_request(CMD_QUERY, 6'd0, 24'h400000, 24'h800000);
    send_request(CMD_QUERY, 6'd0, 24'h7fffff, 24'h7fffff);
    set_vertex_count(3);
    send_request(CMD_QUERY, 6'd0, 24'h100000, 24'h000000);
    send_request(CMD_QUERY, 6'd0, 24'hf00000, 24'h000000);

    // random phases over counts, scales and idle patterns
    for (int ph = 0; ph < 12; ph++) begin
      coord_range = ranges[ph % 4];
      case (ph % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 81; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 81; end
        default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
      endcase
      set_vertex_count(counts[ph]);
      if (ph == 4)
        fork
          begin
            hold_results <= 1'b1;
            repeat (3000) @(posedge clk);
            hold_results <= 1'b0;
          end
        join_none
      for (int k = 0; k < 100; k++) begin
        if (k == 50) drain_results();
        if ($urandom_range(3) == 0)
          send_request(CMD_LOAD, 6'($urandom_range(63)), rand_coord(), rand_coord());
        else
          send_request(CMD_QUERY, 6'($urandom_range(63)), rand_coord(), rand_coord());
      end
    end

    // let the last results come out
    drain_results();
    repeat (1200) @(posedge clk);
    $display("run covered %0d queries over vertex counts 0 to 127 and four idle patterns",
             queries_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: polygon_point_query_core.f
hdl/ppq_pkg.sv
hdl/ppq_vertex_mem.sv
hdl/ppq_div.sv
hdl/polygon_point_query_core.sv
sim/polygon_point_query_checker.sv
sim/polygon_point_query_core_tb.sv
